[design/ttlp_pkg.sv]
`default_nettype none
package ttlp_pkg;

	// fixed field widths
	localparam int LABEL_TEXT_W = 64;
	localparam int VALUE_W      = 32;
	localparam int VLEN_W       = 6;

	// defaults for the top level parameters
	localparam int LABEL_BYTES_DEF = 8;
	localparam int VALUE_BYTES_DEF = 32;

	// characters with a meaning to the parser
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_N     = 8'h4E;

	// "Checksum" packed first byte low
	localparam logic [LABEL_TEXT_W-1:0] CHECKSUM_LABEL = 64'h6D75736B63656843;

	// decimal magnitude clamp and positive maximum
	localparam logic [VALUE_W-1:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_LABEL = 2'd1,
		MODE_VALUE = 2'd2,
		MODE_HEX   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ON_START = 2'd0,
		ON_O     = 2'd1,
		ON_ON    = 2'd2,
		ON_NONE  = 2'd3
	} on_match_t;

	typedef struct packed {
		logic [LABEL_TEXT_W-1:0] label_text;
		logic [VALUE_W-1:0]      decoded_value;
		logic                    value_is_on;
		logic [VLEN_W-1:0]       value_length;
		logic                    is_checksum_line;
		logic                    checksum_ok;
	} result_t;

endpackage
`default_nettype wire

[design/text_telemetry_line_parser_top.sv]
`default_nettype none
// Line parser for a text telemetry byte stream. One received byte is taken
// per item and the parser accepts a byte in every clock cycle while
// in_stall is low: the whole per-byte update (mode change, label capture,
// decimal shift-add, running byte sum) is one level of logic into the
// state registers, and a closed line is written into a result register
// in the same cycle. A newline opens a label, a tab switches to the value,
// a carriage return closes the line and produces one result item; all
// other bytes produce none. A colon in a label enters hex mode, skipped
// until the next newline. Over-long labels or values drop the line. On a
// "Checksum" line checksum_ok tells whether the running sum was zero, and
// the sum then restarts. Results go through a two-entry output buffer
// (result register plus skid register): in_stall rises only when both are
// full, so input bytes keep flowing while one result waits to be taken.
module text_telemetry_line_parser_top #(
	parameter int LABEL_BYTES = ttlp_pkg::LABEL_BYTES_DEF,
	parameter int VALUE_BYTES = ttlp_pkg::VALUE_BYTES_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [7:0]                          rx_byte,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [ttlp_pkg::LABEL_TEXT_W-1:0]        label_text,
	output logic signed [ttlp_pkg::VALUE_W-1:0]      decoded_value,
	output logic                                     value_is_on,
	output logic [ttlp_pkg::VLEN_W-1:0]              value_length,
	output logic                                     is_checksum_line,
	output logic                                     checksum_ok
);

	localparam int LW    = LABEL_BYTES * 8;
	localparam int CNT_W = $clog2(LABEL_BYTES + 1);
	localparam int LABEL_TEXT_W_LOCAL = ttlp_pkg::LABEL_TEXT_W;

	// parser state
	ttlp_pkg::mode_t                 mode_q, mode_d;
	logic [LW-1:0]                   label_q, label_d;
	logic [CNT_W-1:0]                lcnt_q, lcnt_d;
	logic [ttlp_pkg::VLEN_W-1:0]     vcnt_q, vcnt_d;
	logic [ttlp_pkg::VALUE_W-1:0]    acc_q, acc_d;
	logic                            neg_q, neg_d;
	logic                            dend_q, dend_d;
	ttlp_pkg::on_match_t             onm_q, onm_d;
	logic [7:0]                      sum_q, sum_d;

	// output buffer
	ttlp_pkg::result_t               out_q, skid_q, res_new;
	logic                            out_valid_q, skid_valid_q;

	logic                            accept;
	logic                            emit;
	logic                            is_ck;
	logic                            is_digit;
	logic [35:0]                     mag_ext;
	logic [LABEL_TEXT_W_LOCAL-1:0]   label_ext;

	assign accept   = in_valid && !in_stall;
	assign in_stall = skid_valid_q;

	assign label_ext = LABEL_TEXT_W_LOCAL'(label_q);
	assign is_ck     = (label_ext == ttlp_pkg::CHECKSUM_LABEL);
	assign is_digit  = (rx_byte >= ttlp_pkg::CH_ZERO) && (rx_byte <= ttlp_pkg::CH_NINE);

	// acc * 10 + digit, wide enough to see the clamp
	assign mag_ext = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ 36'(rx_byte - ttlp_pkg::CH_ZERO);

	// next mode
	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			ttlp_pkg::MODE_LABEL: begin
				if (rx_byte == ttlp_pkg::CH_TAB) begin
					mode_d = ttlp_pkg::MODE_VALUE;
				end else if (rx_byte == ttlp_pkg::CH_COLON) begin
					mode_d = ttlp_pkg::MODE_HEX;
				end else if (lcnt_q >= CNT_W'(LABEL_BYTES)) begin
					// label too long, drop the line
					mode_d = ttlp_pkg::MODE_IDLE;
				end
			end
			ttlp_pkg::MODE_VALUE: begin
				if (rx_byte == ttlp_pkg::CH_CR) begin
					mode_d = ttlp_pkg::MODE_IDLE;
				end else if (vcnt_q >= ttlp_pkg::VLEN_W'(VALUE_BYTES)) begin
					// value too long, drop the line
					mode_d = ttlp_pkg::MODE_IDLE;
				end
			end
			default: begin
				// idle and hex wait for a newline
				if (rx_byte == ttlp_pkg::CH_NL) begin
					mode_d = ttlp_pkg::MODE_LABEL;
				end
			end
		endcase
	end

	// datapath and result
	always_comb begin
		label_d = label_q;
		lcnt_d  = lcnt_q;
		vcnt_d  = vcnt_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		dend_d  = dend_q;
		onm_d   = onm_q;
		emit    = 1'b0;
		case (mode_q)
			ttlp_pkg::MODE_LABEL: begin
				if (rx_byte == ttlp_pkg::CH_TAB) begin
					vcnt_d = '0;
					acc_d  = '0;
					neg_d  = 1'b0;
					dend_d = 1'b0;
					onm_d  = ttlp_pkg::ON_START;
				end else if (rx_byte != ttlp_pkg::CH_COLON
						&& lcnt_q < CNT_W'(LABEL_BYTES)) begin
					for (int i = 0; i < LABEL_BYTES; i++) begin
						if (lcnt_q == CNT_W'(i)) begin
							label_d[i*8 +: 8] = rx_byte;
						end
					end
					lcnt_d = lcnt_q + 1'b1;
				end
			end
			ttlp_pkg::MODE_VALUE: begin
				if (rx_byte == ttlp_pkg::CH_CR) begin
					emit = 1'b1;
				end else if (vcnt_q < ttlp_pkg::VLEN_W'(VALUE_BYTES)) begin
					// "ON" tracker
					if (vcnt_q == '0) begin
						onm_d = (rx_byte == ttlp_pkg::CH_O) ? ttlp_pkg::ON_O
							: ttlp_pkg::ON_NONE;
					end else if (vcnt_q == ttlp_pkg::VLEN_W'(1)) begin
						onm_d = (onm_q == ttlp_pkg::ON_O && rx_byte == ttlp_pkg::CH_N)
							? ttlp_pkg::ON_ON : ttlp_pkg::ON_NONE;
					end else begin
						onm_d = ttlp_pkg::ON_NONE;
					end
					// decimal reader
					if (!dend_q) begin
						if (is_digit) begin
							acc_d = (mag_ext > 36'(ttlp_pkg::MAG_LIMIT))
								? ttlp_pkg::MAG_LIMIT : mag_ext[31:0];
						end else if (vcnt_q == '0 && (rx_byte == ttlp_pkg::CH_PLUS
								|| rx_byte == ttlp_pkg::CH_MINUS)) begin
							neg_d = (rx_byte == ttlp_pkg::CH_MINUS);
						end else begin
							dend_d = 1'b1;
						end
					end
					vcnt_d = vcnt_q + 1'b1;
				end
			end
			default: begin
				if (rx_byte == ttlp_pkg::CH_NL) begin
					label_d = '0;
					lcnt_d  = '0;
				end
			end
		endcase

		// running sum: cleared by a checksum line, then the byte is added
		// unless the parser now sits in hex mode
		sum_d = (emit && is_ck) ? 8'h00 : sum_q;
		if (mode_d != ttlp_pkg::MODE_HEX) begin
			sum_d = sum_d + rx_byte;
		end

		res_new.label_text       = label_ext;
		res_new.decoded_value    = neg_q ? (ttlp_pkg::VALUE_W'(0) - acc_q)
			: ((acc_q > ttlp_pkg::POS_MAX) ? ttlp_pkg::POS_MAX : acc_q);
		res_new.value_is_on      = (onm_q == ttlp_pkg::ON_ON);
		res_new.value_length     = vcnt_q;
		res_new.is_checksum_line = is_ck;
		res_new.checksum_ok      = is_ck && (sum_q == 8'h00);
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ttlp_pkg::MODE_IDLE;
			label_q <= '0;
			lcnt_q  <= '0;
			vcnt_q  <= '0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			dend_q  <= 1'b0;
			onm_q   <= ttlp_pkg::ON_START;
			sum_q   <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			label_q <= label_d;
			lcnt_q  <= lcnt_d;
			vcnt_q  <= vcnt_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			dend_q  <= dend_d;
			onm_q   <= onm_d;
			sum_q   <= sum_d;
		end
	end

	// output buffer: result register with a skid register behind it;
	// the skid only fills while a result is stalled, and then holds input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept && emit) begin
				if (!out_valid_q || !out_stall) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_valid_q && !out_stall) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			if (!out_valid_q || !out_stall) begin
				out_q <= res_new;
			end else begin
				skid_q <= res_new;
			end
		end else if (out_valid_q && !out_stall && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign label_text       = out_q.label_text;
	assign decoded_value    = out_q.decoded_value;
	assign value_is_on      = out_q.value_is_on;
	assign value_length     = out_q.value_length;
	assign is_checksum_line = out_q.is_checksum_line;
	assign checksum_ok      = out_q.checksum_ok;

	// skid holds a result only behind a full result register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while result register empty");

	// a fresh result only follows a carriage return taken in value mode
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(accept && mode_q == ttlp_pkg::MODE_VALUE
			&& rx_byte == ttlp_pkg::CH_CR))
		else $error("result without a closed line");

	// counters never pass their limits
	a_count_limits: assert property (@(posedge clk) disable iff (!arst_n)
		lcnt_q <= CNT_W'(LABEL_BYTES) && vcnt_q <= ttlp_pkg::VLEN_W'(VALUE_BYTES))
		else $error("label or value count beyond limit");

	// checksum_ok only on a checksum line
	a_ck_ok_on_ck_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.checksum_ok |-> out_q.is_checksum_line)
		else $error("checksum_ok set on an ordinary line");

endmodule
`default_nettype wire
